### rtl/isd_pkg.sv
package isd_pkg;

	typedef logic signed [31:0] word_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic  ins;    // insert the broadcast word
		logic  shift;  // drain: take the neighbor's entry
		word_t x;      // word being inserted
	} cell_ctl_t;

	// What a cell hands to its neighbors
	typedef struct packed {
		word_t value;
		logic  valid;
		logic  keep;   // valid and value >= inserted word
	} cell_link_t;

endpackage

### rtl/isd_ifs.sv
interface isd_in_if;
	import isd_pkg::*;

	logic  valid;
	logic  ready;
	word_t sample_value;
	logic  end_of_set;

	modport source (output valid, output sample_value, output end_of_set, input ready);
	modport sink   (input valid, input sample_value, input end_of_set, output ready);
endinterface

interface isd_out_if;
	import isd_pkg::*;

	logic  valid;
	logic  ready;
	word_t sorted_value;
	logic  last_of_run;
	logic  overflowed;

	modport source (output valid, output sorted_value, output last_of_run,
		output overflowed, input ready);
	modport sink   (input valid, input sorted_value, input last_of_run,
		input overflowed, output ready);
endinterface

### rtl/insertion_sort_descending.sv
// Descending insertion sorter built as a chain of compare-and-hold cells.
//
// samples (sink): one signed word per accepted handshake. Each word is
//   inserted into the chain in parallel: every cell compares its entry
//   with the broadcast word and either holds, takes the word, or takes its
//   head-side neighbor's entry. Equal words keep arrival order.
// A word flagged end_of_set is inserted too, then the block stops taking
//   input and drains the chain head first on results (source), one word per
//   cycle the receiver is ready. last_of_run marks the smallest word;
//   overflowed is set on every word of the run if any word of the set was
//   dropped because all STORE_DEPTH cells were full.
// Throughput: one input word per cycle while filling; the stored words are
//   then emitted on results, during which samples.ready is low. The chain
//   is the only storage, so fill and drain do not overlap. First result is
//   offered the cycle after the end_of_set word is accepted.
// Receiver stall: the chain simply holds; nothing is lost.
// Reset: all cells empty, overflow flag clear, block ready for input.
module insertion_sort_descending #(
	parameter int STORE_DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	isd_in_if.sink    samples,
	isd_out_if.source results
);
	import isd_pkg::*;

	cell_ctl_t  ctl;
	cell_link_t links [STORE_DEPTH];
	logic       drain_q;    // emitting the stored set
	logic       dropped_q;  // a word of this set did not fit
	logic       in_fire;
	logic       out_fire;
	logic       full;

	assign full     = links[STORE_DEPTH-1].valid;
	assign in_fire  = samples.valid && samples.ready;
	assign out_fire = results.valid && results.ready;

	assign samples.ready = !drain_q;

	assign ctl.ins   = in_fire && !full;
	assign ctl.shift = out_fire;
	assign ctl.x     = samples.sample_value;

	// head cell is the output; tail of the run is where the next cell is empty
	assign results.valid        = drain_q && links[0].valid;
	assign results.sorted_value = links[0].value;
	assign results.last_of_run  = !links[1].valid;
	assign results.overflowed   = dropped_q;

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		cell_link_t prev_l;
		cell_link_t next_l;

		if (i == 0) begin : g_head
			// virtual head neighbor: always valid, always ahead of the new word
			assign prev_l = '{value: '0, valid: 1'b1, keep: 1'b1};
		end else begin : g_mid
			assign prev_l = links[i-1];
		end

		if (i == STORE_DEPTH - 1) begin : g_tail
			assign next_l = '{value: '0, valid: 1'b0, keep: 1'b0};
		end else begin : g_body
			assign next_l = links[i+1];
		end

		isd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   (prev_l),
			.next   (next_l),
			.link   (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (in_fire && full) begin
				dropped_q <= 1'b1;
			end
			if (in_fire && samples.end_of_set) begin
				drain_q <= 1'b1;
			end
			if (out_fire && results.last_of_run) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/isd_cell.sv
module isd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  isd_pkg::cell_ctl_t ctl,
	input  isd_pkg::cell_link_t prev,  // neighbor toward the head (larger values)
	input  isd_pkg::cell_link_t next,  // neighbor toward the tail
	output isd_pkg::cell_link_t link
);
	import isd_pkg::*;

	word_t value_q;
	logic  valid_q;
	logic  keep;

	assign keep = valid_q && (value_q >= ctl.x);

	assign link.value = value_q;
	assign link.valid = valid_q;
	assign link.keep  = keep;

	// payload: no reset, read only under valid
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= next.value;
		end else if (ctl.ins && !keep) begin
			value_q <= prev.keep ? ctl.x : prev.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next.valid;
		end else if (ctl.ins) begin
			valid_q <= valid_q | prev.valid;
		end
	end

endmodule

### rtl/isd_checker.sv
module isd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_end,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic out_ovf
);

	// no input taken while a run is being emitted
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while results pending");

	// end of set starts the run on the next cycle
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_end) |=> (out_valid && !in_ready))
		else $error("run did not start after end of set");

	// last word closes the run and reopens the input
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
		else $error("run did not end after last word");

	// overflow flag is constant through a run
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid)) |-> $stable(out_ovf))
		else $error("overflow flag changed within a run");

endmodule

bind insertion_sort_descending isd_checker u_isd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_end    (samples.end_of_set),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_last  (results.last_of_run),
	.out_ovf   (results.overflowed)
);
